@@ hw/rtl/tpr_pkg.sv @@
// Shared widths, constants and unit request types for the thruster pulse-width block.
// No dependencies; imported by every module of the block.
`default_nettype none
package tpr_pkg;

	localparam int NUM_THRUSTERS = 8;
	localparam int IDX_W   = 3;
	localparam int CNT_W   = 4;
	localparam int TIME_W  = 63;
	localparam int REQ_W   = 32;
	localparam int MT_W    = 32;
	localparam int MP_W    = 32;
	localparam int REM_W   = 16;
	localparam int PER_W   = 40;
	localparam int ON_W    = 42;
	localparam int CORR_W  = 33;

	// serial multiplier: A operand, B operand (consumed LSB first), product
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 40;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int MUL_N_W = 6;

	// serial divider: dividend fed MSB first, divisor, quotient
	localparam int DIV_D_W = 74;
	localparam int DIV_V_W = 32;
	localparam int DIV_Q_W = 42;
	localparam int DIV_N_W = 7;

	localparam int S_DATA_W = 168;
	localparam int M_DATA_W = 48;

	localparam logic [ON_W-1:0]   ON_CAP        = {2'b10, 40'd0};
	localparam logic [PER_W-1:0]  OUT_MAX       = {PER_W{1'b1}};
	localparam logic [PER_W-1:0]  FIRST_STEP_NS = 40'd2000000000;
	localparam logic [DIV_V_W-1:0] TEN          = 32'd10;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
		logic [MUL_N_W-1:0] n;
	} mul_req_t;

	typedef struct packed {
		logic               start;
		logic [DIV_D_W-1:0] dividend;
		logic [DIV_V_W-1:0] divisor;
		logic [DIV_N_W-1:0] n;
	} div_req_t;

endpackage
`default_nettype wire

@@ hw/rtl/tpr_serial_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on tpr_pkg.
`default_nettype none
module tpr_serial_mul (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tpr_pkg::mul_req_t          req,
	output logic                            busy,
	output logic                            done,
	output logic [tpr_pkg::MUL_P_W-1:0]     product
);
	import tpr_pkg::*;

	logic [MUL_A_W-1:0] a_q;
	logic [MUL_P_W-1:0] p_q;
	logic [MUL_N_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_A_W:0]   sum;

	// add A into the top half when the current multiplier bit is set
	assign sum = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.n;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_N_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			p_q <= {{MUL_A_W{1'b0}}, req.b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[MUL_B_W-1:1]};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = p_q;

endmodule
`default_nettype wire

@@ hw/rtl/tpr_serial_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, dividend fed MSB first.
// Quotient bits above its width set a sticky overflow flag. Depends on tpr_pkg.
`default_nettype none
module tpr_serial_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tpr_pkg::div_req_t          req,
	output logic                            busy,
	output logic                            done,
	output logic [tpr_pkg::DIV_Q_W-1:0]     quotient,
	output logic                            overflow
);
	import tpr_pkg::*;

	logic [DIV_D_W-1:0] d_q;
	logic [DIV_V_W-1:0] v_q;
	logic [DIV_V_W-1:0] r_q;
	logic [DIV_Q_W-1:0] q_q;
	logic               ovf_q;
	logic [DIV_N_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_V_W:0]   r2;
	logic [DIV_V_W:0]   rdiff;
	logic               ge;

	// trial subtract of the shifted partial remainder
	assign r2    = {r_q, d_q[DIV_D_W-1]};
	assign ge    = r2 >= {1'b0, v_q};
	assign rdiff = r2 - {1'b0, v_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.n;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_N_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			d_q   <= req.dividend;
			v_q   <= req.divisor;
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			d_q   <= {d_q[DIV_D_W-2:0], 1'b0};
			r_q   <= ge ? rdiff[DIV_V_W-1:0] : r2[DIV_V_W-1:0];
			q_q   <= {q_q[DIV_Q_W-2:0], ge};
			ovf_q <= ovf_q | q_q[DIV_Q_W-1];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = q_q;
	assign overflow = ovf_q;

endmodule
`default_nettype wire

@@ hw/rtl/thruster_pulse_remainder_pwm_top.sv @@
// Top level: settings tables, step timing, sequencer and output register.
// Depends on tpr_pkg, tpr_serial_mul and tpr_serial_div.
//
// Usage. Words enter on the s_ channel (tvalid/tready). s_tuser is the
// operation: a load word stores one thruster's maximum thrust, minimum pulse
// and base state and gives no result. A request word with step_start set
// first updates the step timing from call_time_ns; from the second step
// start on this sets the control period. A served request gives one result
// word on the m_ channel; requests before the first step start or for
// thrusters at or above thruster_count give none. A first-step request goes
// straight to the output stage. A normal request runs a multiply, a divide,
// a multiply and then either a divide (short pulse), a divide (saturated
// pulse) or nothing; with zero maximum thrust the first divide is skipped.
// The sequencer returns to idle as the result is loaded into the output
// register, so the next word can be taken while the result is valid. One
// request is worked at a time; the shared bit-serial units set the rate. The
// result sits in an output register: a new word is accepted while it waits,
// and a stalled receiver holds the sequencer before its next result. Reset
// clears base states, remainders and step timing, and sets thruster_count
// to 8. Configuration is always ready.
`default_nettype none
module thruster_pulse_remainder_pwm_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tpr_pkg::CNT_W-1:0]     cfg_data,    // thruster_count
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// thruster[2:0], step_start[3], call_time_ns[66:4], thrust_request[98:67],
	// max_thrust[130:99], min_pulse_ns[162:131], base_on[163], zero pad
	input  wire logic [tpr_pkg::S_DATA_W-1:0]  s_tdata,
	input  wire logic                          s_tuser,     // operation
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// thruster_out[2:0], on_time_ns[42:3], zero pad
	output logic [tpr_pkg::M_DATA_W-1:0]       m_tdata,
	output logic                               m_tuser      // initial_step
);
	import tpr_pkg::*;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_CORR      = 4'd1;
	localparam logic [3:0] S_MUL_RATIO = 4'd2;
	localparam logic [3:0] S_DIV_RATIO = 4'd3;
	localparam logic [3:0] S_MUL_REM   = 4'd4;
	localparam logic [3:0] S_SUM       = 4'd5;
	localparam logic [3:0] S_DEC       = 4'd6;
	localparam logic [3:0] S_DIV_SHORT = 4'd7;
	localparam logic [3:0] S_DIV_OVER  = 4'd8;
	localparam logic [3:0] S_OUT       = 4'd9;

	// input word fields
	logic [IDX_W-1:0]  in_idx;
	logic              in_ss;
	logic [TIME_W-1:0] in_time;
	logic [REQ_W-1:0]  in_req;
	logic [MT_W-1:0]   in_mt;
	logic [MP_W-1:0]   in_mp;
	logic              in_base;

	assign in_idx  = s_tdata[2:0];
	assign in_ss   = s_tdata[3];
	assign in_time = s_tdata[66:4];
	assign in_req  = s_tdata[98:67];
	assign in_mt   = s_tdata[130:99];
	assign in_mp   = s_tdata[162:131];
	assign in_base = s_tdata[163];

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [MT_W-1:0]   mt_table_q [NUM_THRUSTERS];
	logic [MP_W-1:0]   mp_table_q [NUM_THRUSTERS];
	logic [NUM_THRUSTERS-1:0] base_q;
	logic [REM_W-1:0]  rem_table_q [NUM_THRUSTERS];
	logic [TIME_W-1:0] prev_time_q;
	logic              started_q;
	logic              first_q;
	logic [PER_W-1:0]  period_q;

	logic [IDX_W-1:0]  idx_q;
	logic [REQ_W-1:0]  req_q;
	logic              corr_nz_q;
	logic [ON_W-1:0]   ratio_q;
	logic [ON_W-1:0]   on_q;
	logic [PER_W-1:0]  res_on_q;
	logic              res_init_q;
	logic              m_tvalid_q;
	logic [IDX_W-1:0]  m_idx_q;
	logic [PER_W-1:0]  m_on_q;
	logic              m_init_q;

	mul_req_t mul_req;
	div_req_t div_req;
	logic     mul_busy, mul_done, div_busy, div_done, div_ovf;
	logic [MUL_P_W-1:0] mul_prod;
	logic [DIV_Q_W-1:0] div_q;

	tpr_serial_mul u_mul (
		.clk(clk), .arst_n(arst_n), .req(mul_req),
		.busy(mul_busy), .done(mul_done), .product(mul_prod)
	);

	tpr_serial_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req),
		.busy(div_busy), .done(div_done), .quotient(div_q), .overflow(div_ovf)
	);

	// current thruster's settings
	logic [MT_W-1:0]  mt_cur;
	logic [MP_W-1:0]  mp_cur;
	logic [REM_W-1:0] rem_cur;
	assign mt_cur  = mt_table_q[idx_q];
	assign mp_cur  = mp_table_q[idx_q];
	assign rem_cur = rem_table_q[idx_q];

	// off-pulsing correction and clamp at zero
	logic signed [CORR_W:0] corr_full;
	logic [CORR_W-1:0]      corr_c;
	assign corr_full = $signed({{2{req_q[REQ_W-1]}}, req_q})
		+ $signed({2'b00, (base_q[idx_q] ? mt_cur : {MT_W{1'b0}})});
	assign corr_c = corr_full[CORR_W] ? '0 : corr_full[CORR_W-1:0];

	// step period from the incoming call time
	logic [TIME_W:0]   tdiff;
	logic [PER_W-1:0]  period_new;
	assign tdiff      = {1'b0, in_time} - {1'b0, prev_time_q};
	assign period_new = tdiff[TIME_W] ? '0
		: (|tdiff[TIME_W-1:PER_W] ? OUT_MAX : tdiff[PER_W-1:0]);

	logic accept, is_req, served, first_now;
	assign accept    = s_tvalid && s_tready;
	assign is_req    = s_tuser == OP_REQUEST;
	assign served    = (started_q || in_ss) && ({1'b0, in_idx} < count_q);
	assign first_now = in_ss ? !started_q : first_q;

	// saturated sums and limits
	logic [ON_W:0]     on_sum;
	logic [ON_W-1:0]   ratio_sat;
	logic [PER_W+3:0]  period_x11;
	assign ratio_sat  = (div_ovf || div_q > ON_CAP) ? ON_CAP : div_q;
	assign on_sum     = {1'b0, ratio_q} + {{(ON_W-MUL_A_W+1){1'b0}},
		mul_prod[MUL_P_W-1:MUL_B_W]};
	assign period_x11 = {1'b0, period_q, 3'b000} + {3'b000, period_q, 1'b0}
		+ {4'b0000, period_q};

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// unit requests
	always_comb begin
		mul_req = '0;
		div_req = '0;
		unique case (state_q)
			S_CORR: begin
				mul_req.start = 1'b1;
				mul_req.a     = {1'b0, corr_c};
				mul_req.b     = period_q;
				mul_req.n     = MUL_N_W'(MUL_B_W);
			end
			S_MUL_RATIO: begin
				if (mul_done && mt_cur != '0) begin
					div_req.start    = 1'b1;
					div_req.dividend = mul_prod;
					div_req.divisor  = mt_cur;
					div_req.n        = DIV_N_W'(DIV_D_W);
				end else if (mul_done) begin
					mul_req.start = 1'b1;
					mul_req.a     = {2'b00, mp_cur};
					mul_req.b     = {{(MUL_B_W-REM_W){1'b0}}, rem_cur};
					mul_req.n     = MUL_N_W'(REM_W);
				end
			end
			S_DIV_RATIO: begin
				if (div_done) begin
					mul_req.start = 1'b1;
					mul_req.a     = {2'b00, mp_cur};
					mul_req.b     = {{(MUL_B_W-REM_W){1'b0}}, rem_cur};
					mul_req.n     = MUL_N_W'(REM_W);
				end
			end
			S_DEC: begin
				if (on_q < {{(ON_W-MP_W){1'b0}}, mp_cur}) begin
					div_req.start    = 1'b1;
					div_req.dividend = {on_q[MP_W-1:0], {(DIV_D_W-MP_W){1'b0}}};
					div_req.divisor  = mp_cur;
					div_req.n        = DIV_N_W'(MP_W + REM_W);
				end else if (on_q >= {2'b00, period_q}) begin
					div_req.start    = 1'b1;
					div_req.dividend = {period_x11, {(DIV_D_W-PER_W-4){1'b0}}};
					div_req.divisor  = TEN;
					div_req.n        = DIV_N_W'(PER_W + 4);
				end
			end
			default: begin
			end
		endcase
	end

	// settings tables have no reset
	always_ff @(posedge clk) begin
		if (accept && s_tuser == OP_LOAD) begin
			mt_table_q[in_idx] <= in_mt;
			mp_table_q[in_idx] <= in_mp;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= in_idx;
			req_q <= in_req;
		end
		if (state_q == S_CORR)
			corr_nz_q <= |corr_c;
		if (state_q == S_MUL_RATIO && mul_done && mt_cur == '0)
			ratio_q <= corr_nz_q ? ON_CAP : '0;
		if (state_q == S_DIV_RATIO && div_done)
			ratio_q <= ratio_sat;
		if (state_q == S_SUM)
			on_q <= on_sum[ON_W] || on_sum[ON_W-1:0] > ON_CAP ? ON_CAP : on_sum[ON_W-1:0];
		if (state_q == S_OUT && out_free) begin
			m_idx_q  <= idx_q;
			m_on_q   <= res_on_q;
			m_init_q <= res_init_q;
		end
	end

	// sequencer, step state and reset-cleared tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CNT_W'(NUM_THRUSTERS);
			base_q      <= '0;
			rem_table_q <= '{default: '0};
			prev_time_q <= '0;
			started_q   <= 1'b0;
			first_q     <= 1'b0;
			period_q    <= '0;
			res_on_q    <= '0;
			res_init_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid)
				count_q <= cfg_data;
			// output stage loads a new word itself
			if (m_tvalid_q && m_tready && state_q != S_OUT)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept && !is_req) begin
						base_q[in_idx] <= in_base;
					end else if (accept) begin
						if (in_ss) begin
							prev_time_q <= in_time;
							if (!started_q) begin
								started_q <= 1'b1;
								first_q   <= 1'b1;
							end else begin
								period_q <= period_new;
								first_q  <= 1'b0;
							end
						end
						if (served && first_now) begin
							res_on_q   <= base_q[in_idx] ? FIRST_STEP_NS : '0;
							res_init_q <= 1'b1;
							state_q    <= S_OUT;
						end else if (served) begin
							res_init_q <= 1'b0;
							state_q    <= S_CORR;
						end
					end
				end
				S_CORR:      state_q <= S_MUL_RATIO;
				S_MUL_RATIO: begin
					if (mul_done)
						state_q <= (mt_cur != '0) ? S_DIV_RATIO : S_MUL_REM;
				end
				S_DIV_RATIO: begin
					if (div_done)
						state_q <= S_MUL_REM;
				end
				S_MUL_REM: begin
					if (mul_done)
						state_q <= S_SUM;
				end
				S_SUM:       state_q <= S_DEC;
				S_DEC: begin
					rem_table_q[idx_q] <= '0;
					if (on_q < {{(ON_W-MP_W){1'b0}}, mp_cur}) begin
						state_q <= S_DIV_SHORT;
					end else if (on_q >= {2'b00, period_q}) begin
						state_q <= S_DIV_OVER;
					end else begin
						res_on_q <= on_q[PER_W-1:0];
						state_q  <= S_OUT;
					end
				end
				S_DIV_SHORT: begin
					if (div_done) begin
						rem_table_q[idx_q] <= div_q[REM_W-1:0];
						res_on_q           <= '0;
						state_q            <= S_OUT;
					end
				end
				S_DIV_OVER: begin
					if (div_done) begin
						res_on_q <= (|div_q[DIV_Q_W-1:PER_W]) ? OUT_MAX : div_q[PER_W-1:0];
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = state_q == S_IDLE;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{(M_DATA_W-PER_W-IDX_W){1'b0}}, m_on_q, m_idx_q};
	assign m_tuser   = m_init_q;

	// the two arithmetic units never run together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && div_busy)) else $error("multiplier and divider both busy");

	// once a step has started it stays started
	a_started_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q) else $error("started flag cleared");

	// a divider result arrives only in a state that waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_RATIO || state_q == S_DIV_SHORT
			|| state_q == S_DIV_OVER)) else $error("stray divider result");

	// a served first-step request goes straight to the output stage
	a_first_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_req && served && first_now) |=> state_q == S_OUT)
		else $error("first-step result not issued");

endmodule
`default_nettype wire

@@ bench/thruster_pulse_remainder_pwm_top_tb.sv @@
// Self-checking bench for the thruster pulse-width block with minimum-pulse remainder.
// Depends on tpr_pkg and thruster_pulse_remainder_pwm_top; predicts every on-time word
// in step with the s_ channel and checks each m_ word in order.
`default_nettype none
module thruster_pulse_remainder_pwm_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tpr_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 250;
	localparam logic [63:0] PULSE_CAP = 64'd1 << 41;

	typedef struct {
		logic              op;
		logic [IDX_W-1:0]  thr;
		logic              ss;
		logic [TIME_W-1:0] t;
		logic [REQ_W-1:0]  req;
		logic [MT_W-1:0]   mt;
		logic [MP_W-1:0]   mp;
		logic              bo;
	} pwm_word_t;

	typedef struct {
		logic [IDX_W-1:0] thr;
		logic [PER_W-1:0] on_ns;
		logic             initial_step;
	} on_time_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic m_tuser;

	thruster_pulse_remainder_pwm_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// predictor state
	logic [MT_W-1:0]  mt_tab [NUM_THRUSTERS];
	logic [MP_W-1:0]  mp_tab [NUM_THRUSTERS];
	logic             bo_tab [NUM_THRUSTERS];
	logic [REM_W-1:0] rem_tab [NUM_THRUSTERS];
	logic [63:0]      prev_time = '0;
	logic             stepped = 1'b0;
	logic             first_step = 1'b0;
	logic [PER_W-1:0] period = '0;
	int unsigned      active_count = 8;

	pwm_word_t pending_words[$];
	on_time_t  expected_on[$];
	pwm_word_t cur_word;
	int errors = 0, checked = 0, short_pulses = 0, saturated = 0, initial_words = 0;
	int gap_left = 0, stall_left = 0, idle_cycles = 0;
	logic quiet = 1'b0;
	logic [TIME_W-1:0] stim_time = '0;

	initial begin
		for (int i = 0; i < NUM_THRUSTERS; i++) begin
			mt_tab[i] = '0; mp_tab[i] = '0; bo_tab[i] = 1'b0; rem_tab[i] = '0;
		end
	end

	task automatic report(input string what, input on_time_t got, input on_time_t want);
		$display("mismatch %s: got thr %0d on %0d init %0b, want thr %0d on %0d init %0b",
			what, got.thr, got.on_ns, got.initial_step, want.thr, want.on_ns,
			want.initial_step);
		errors++;
	endtask

	// on-time prediction for one accepted word
	task automatic predict_on_time(input pwm_word_t w);
		longint signed corr;
		logic [79:0] prod;
		logic [63:0] on, rterm, diff;
		on_time_t r;
		if (w.op == OP_LOAD) begin
			mt_tab[w.thr] = w.mt; mp_tab[w.thr] = w.mp; bo_tab[w.thr] = w.bo;
			return;
		end
		if (w.ss) begin
			if (!stepped) begin
				stepped = 1'b1;
				first_step = 1'b1;
			end else begin
				diff = ({1'b0, w.t} >= prev_time) ? {1'b0, w.t} - prev_time : 64'd0;
				period = (diff > {24'd0, OUT_MAX}) ? OUT_MAX : diff[PER_W-1:0];
				first_step = 1'b0;
			end
			prev_time = {1'b0, w.t};
		end
		if (!stepped || w.thr >= active_count)
			return;
		r.thr = w.thr;
		if (first_step) begin
			r.on_ns = bo_tab[w.thr] ? FIRST_STEP_NS : '0;
			r.initial_step = 1'b1;
			initial_words++;
			expected_on.push_back(r);
			return;
		end
		corr = longint'($signed(w.req)) + (bo_tab[w.thr] ? longint'(mt_tab[w.thr]) : 0);
		if (corr < 0)
			corr = 0;
		if (mt_tab[w.thr] == '0) begin
			on = (corr > 0) ? PULSE_CAP : 64'd0;
		end else begin
			prod = 80'(corr) * 80'(period);
			prod = prod / 80'(mt_tab[w.thr]);
			on = (prod > 80'(PULSE_CAP)) ? PULSE_CAP : prod[63:0];
		end
		rterm = (64'(rem_tab[w.thr]) * 64'(mp_tab[w.thr])) >> 16;
		on = on + rterm;
		if (on > PULSE_CAP)
			on = PULSE_CAP;
		rem_tab[w.thr] = '0;
		if (on < 64'(mp_tab[w.thr])) begin
			rem_tab[w.thr] = REM_W'((on << 16) / 64'(mp_tab[w.thr]));
			on = '0;
			short_pulses++;
		end else if (on >= 64'(period)) begin
			on = 64'(period) * 64'd11 / 64'd10;
			if (on > 64'(OUT_MAX))
				on = 64'(OUT_MAX);
			saturated++;
		end
		r.on_ns = on[PER_W-1:0];
		r.initial_step = 1'b0;
		expected_on.push_back(r);
	endtask

	function automatic pwm_word_t mk(input logic op, input int thr, input logic ss,
			input logic [TIME_W-1:0] t, input logic [31:0] req, input logic [31:0] mt,
			input logic [31:0] mp, input logic bo);
		pwm_word_t w;
		w.op = op; w.thr = thr[IDX_W-1:0]; w.ss = ss; w.t = t;
		w.req = req; w.mt = mt; w.mp = mp; w.bo = bo;
		return w;
	endfunction

	// random word: mostly well-formed requests, some loads, occasional odd timing
	function automatic pwm_word_t rand_word();
		pwm_word_t w;
		w = mk(OP_REQUEST, $urandom_range(0, 7), 1'b0, TIME_W'({$urandom, $urandom}),
			$signed($urandom) >>> $urandom_range(0, 24), $urandom, $urandom, 1'($urandom));
		if ($urandom_range(0, 11) == 0) begin
			w.op = OP_LOAD;
			w.mt = $urandom >> $urandom_range(0, 28);
			if (w.mt == 0)
				w.mt = 1;
			w.mp = ($urandom_range(0, 3) == 0) ? ($urandom | 32'd1)
				: $urandom_range(1000, 30000000);
			return w;
		end
		w.ss = ($urandom_range(0, 4) == 0);
		if (w.ss) begin
			case ($urandom_range(0, 19))
				0: stim_time = TIME_W'({$urandom, $urandom});
				1: stim_time = stim_time - TIME_W'($urandom_range(1, 1000000));
				2: ;
				default: stim_time = stim_time + TIME_W'($urandom_range(100000, 50000000));
			endcase
			w.t = stim_time;
		end
		return w;
	endfunction

	// sender: one word at a time, random gaps between words
	always @(posedge clk) begin : sender
		pwm_word_t w;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_on_time(cur_word);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					cur_word = w;
					s_tdata <= {4'd0, w.bo, w.mp, w.mt, w.req, w.t, w.ss, w.thr};
					s_tuser <= w.op;
					s_tvalid <= 1'b1;
					if (!quiet && $urandom_range(0, 7) == 0)
						gap_left = $urandom_range(1, 9);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall bursts, in-order check of each word
	always @(posedge clk) begin : receiver
		on_time_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.thr = m_tdata[2:0];
				got.on_ns = m_tdata[42:3];
				got.initial_step = m_tuser;
				if (expected_on.size() == 0) begin
					want = '{default: '0};
					report("unexpected word", got, want);
				end else begin
					want = expected_on.pop_front();
					checked++;
					if (got.thr != want.thr)
						report("thruster_out", got, want);
					if (got.on_ns != want.on_ns)
						report("on_time_ns", got, want);
					if (got.initial_step != want.initial_step)
						report("initial_step", got, want);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 9);
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// wait until nothing is in flight, then let a request with no result finish
	task automatic drain();
		do @(posedge clk);
		while (pending_words.size() != 0 || s_tvalid || expected_on.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(input int unsigned n);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n[CNT_W-1:0];
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_count = n;
	endtask

	initial begin : stimulus
		int unsigned counts[4];
		logic [TIME_W-1:0] t;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: request before any step, settings extremes, first step
		t = 63'd1000;
		pending_words.push_back(mk(OP_REQUEST, 0, 1'b0, t, 32'h10000, '0, '0, 1'b0));
		pending_words.push_back(mk(OP_LOAD, 0, 1'b0, '0, '0, 32'h0001_0000, 1000000, 1'b0));
		pending_words.push_back(mk(OP_LOAD, 1, 1'b1, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1));
		pending_words.push_back(mk(OP_LOAD, 2, 1'b0, '0, '0, 32'd1, 32'd1, 1'b0));
		pending_words.push_back(mk(OP_LOAD, 3, 1'b0, '0, '0, 32'h000A_0000, 5000000, 1'b1));
		for (int i = 4; i < NUM_THRUSTERS; i++)
			pending_words.push_back(mk(OP_LOAD, i, 1'b0, '0, '0, 32'h0002_0000, 2000000,
				i[0]));
		pending_words.push_back(mk(OP_REQUEST, 0, 1'b1, t, 32'h10000, '0, '0, 1'b0));
		for (int i = 1; i < NUM_THRUSTERS; i++)
			pending_words.push_back(mk(OP_REQUEST, i, 1'b0, t, '0, '0, '0, 1'b0));
		// normal steps: mid-range, negative, overdrive, off-pulsing, short pulse
		t = t + 63'd100000000;
		pending_words.push_back(mk(OP_REQUEST, 0, 1'b1, t, 32'h8000, '0, '0, 1'b0));
		pending_words.push_back(mk(OP_REQUEST, 1, 1'b0, t, 32'h8000_0000, '0, '0, 1'b0));
		pending_words.push_back(mk(OP_REQUEST, 2, 1'b0, t, 32'h7FFF_FFFF, '0, '0, 1'b0));
		pending_words.push_back(mk(OP_REQUEST, 3, 1'b0, t, 32'h0, '0, '0, 1'b0));
		pending_words.push_back(mk(OP_REQUEST, 0, 1'b0, t, 32'h100, '0, '0, 1'b0));
		// remainder carried into the next step
		t = t + 63'd100000000;
		pending_words.push_back(mk(OP_REQUEST, 0, 1'b1, t, 32'h100, '0, '0, 1'b0));
		// time going backwards, then a jump that saturates the period
		pending_words.push_back(mk(OP_REQUEST, 4, 1'b1, 63'd5, 32'h1000, '0, '0, 1'b0));
		pending_words.push_back(mk(OP_REQUEST, 2, 1'b1, {TIME_W{1'b1}}, 32'd1, '0, '0,
			1'b0));
		pending_words.push_back(mk(OP_REQUEST, 5, 1'b0, '0, 32'h7FFF_FFFF, '0, '0, 1'b0));
		stim_time = {TIME_W{1'b1}};
		drain();

		// random phases over several thruster counts, quiet in the last one
		counts[0] = 1; counts[1] = 8; counts[2] = $urandom_range(2, 7); counts[3] = 8;
		for (int p = 0; p < 4; p++) begin
			set_count(counts[p]);
			quiet = (p == 3);
			for (int i = 0; i < 180; i++)
				pending_words.push_back(rand_word());
			drain();
		end

		$display("covered %0d checked words: %0d first-step, %0d short pulses, %0d saturated",
			checked, initial_words, short_pulses, saturated);
		$display("thruster counts 1, 8 and %0d; negative, backward-time and saturated periods",
			counts[2]);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
